// ===== rtl/hfc_pkg.sv =====
// ----------------------------------------------------------------------------
// hfc_pkg
// Types and conversion functions for the binary16 / binary32 converter.
// ----------------------------------------------------------------------------
package hfc_pkg;

	localparam int unsigned ValueWidth = 32;

	typedef enum logic {
		DIR_H2F = 1'b0,
		DIR_F2H = 1'b1
	} dir_t;

	typedef struct packed {
		logic                  req_type;
		logic [ValueWidth-1:0] value_in;
		logic                  last_in;
	} req_t;

	typedef struct packed {
		logic [ValueWidth-1:0] result_bits;
		logic                  last_out;
	} rsp_t;

	// count leading zeros of a 10-bit mantissa (non-zero)
	function automatic logic [3:0] clz10(input logic [9:0] m);
		logic [3:0] n;
		logic       hit;
		n   = 4'd0;
		hit = 1'b0;
		for (int i = 9; i >= 0; i--) begin
			if (!hit && !m[i]) begin
				n = n + 4'd1;
			end else begin
				hit = 1'b1;
			end
		end
		return n;
	endfunction

	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic [31:0] res;
		logic [4:0]  ex;
		logic [9:0]  man;
		logic [3:0]  lz;
		logic [10:0] norm;
		logic [7:0]  e32;
		ex   = h[14:10];
		man  = h[9:0];
		lz   = clz10(man);
		norm = {1'b0, man} << (lz + 4'd1);
		e32  = 8'd112 - {4'd0, lz};
		if (ex == 5'h1F) begin
			if (man == 10'd0) begin
				res = {h[15], 8'hFF, 23'd0};
			end else begin
				res = {h[15], 8'hFF, 1'b1, man[8:0], 13'd0};
			end
		end else if (ex == 5'd0) begin
			if (man == 10'd0) begin
				res = {h[15], 31'd0};
			end else begin
				res = {h[15], e32, norm[9:0], 13'd0};
			end
		end else begin
			res = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
		end
		return res;
	endfunction

	function automatic logic [15:0] single_to_half(input logic [31:0] x);
		logic [15:0] res;
		logic [7:0]  ex;
		logic [22:0] man;
		logic [14:0] h;
		logic [12:0] rem;
		logic [4:0]  shift;
		logic [23:0] full;
		logic [23:0] rem2;
		logic [23:0] halfway;
		logic [23:0] mask;
		logic [10:0] hs;
		ex      = x[30:23];
		man     = x[22:0];
		h       = {5'(ex - 8'd112), man[22:13]};
		rem     = man[12:0];
		shift   = 5'(8'd126 - ex);
		full    = {1'b1, man};
		mask    = (24'd1 << shift) - 24'd1;
		rem2    = full & mask;
		halfway = 24'd1 << (shift - 5'd1);
		hs      = 11'(full >> shift);
		if (ex == 8'hFF) begin
			res = (man == 23'd0) ? {x[31], 15'h7C00} :
				{x[31], 5'h1F, 1'b1, man[21:13]};
		end else if (ex >= 8'd143) begin
			res = {x[31], 15'h7C00};
		end else if (ex >= 8'd113) begin
			if (rem > 13'h1000 || (rem == 13'h1000 && h[0])) begin
				h = h + 15'd1;
			end
			res = {x[31], h};
		end else if (ex < 8'd102) begin
			res = {x[31], 15'd0};
		end else begin
			if (rem2 > halfway || (rem2 == halfway && hs[0])) begin
				hs = hs + 11'd1;
			end
			res = {x[31], 4'd0, hs};
		end
		return res;
	endfunction

endpackage

// ===== rtl/hfc_stream_if.sv =====
// ----------------------------------------------------------------------------
// hfc_stream_if
// Valid / ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface hfc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/hfc_convert.sv =====
// ----------------------------------------------------------------------------
// hfc_convert
// Combinational conversion of one request word into one result word.
// ----------------------------------------------------------------------------
module hfc_convert import hfc_pkg::*; (
	input  req_t req,
	output rsp_t rsp
);
	always_comb begin
		rsp.last_out = req.last_in;
		if (dir_t'(req.req_type) == DIR_H2F) begin
			rsp.result_bits = half_to_single(req.value_in[15:0]);
		end else begin
			rsp.result_bits = {16'd0, single_to_half(req.value_in)};
		end
	end
endmodule

// ===== rtl/half_float_converter.sv =====
// ----------------------------------------------------------------------------
// half_float_converter
// Streaming binary16 / binary32 conversion, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   req carries req_type, value_in and last_in; rsp carries result_bits and
//   last_out. Both are valid/ready channels, a word moves when both are high.
//   A request word is captured in the input register (_s1), converted by
//   single-pass logic and held in the result register (_s2).
//   Path: the word moves from _s1 through the conversion into _s2, where
//   rsp.valid rises; a stalled result in _s2 holds it back in _s1.
//   Throughput: one word per cycle while rsp.ready is high.
//   While rsp.ready is low, the result register holds; the input register
//   still takes one more word if it is empty, then req.ready drops.
//   Reset clears both valid flags; no word is in flight afterwards.
// ----------------------------------------------------------------------------
module half_float_converter import hfc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	hfc_stream_if.sink   req,
	hfc_stream_if.source rsp
);
	req_t data_s1;
	logic valid_s1;
	rsp_t conv;
	rsp_t data_s2;
	logic valid_s2;
	logic adv_s2;

	assign adv_s2    = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv_s2;

	hfc_convert u_convert (
		.req(data_s1),
		.rsp(conv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			data_s1 <= req.data;
		end
		if (adv_s2) begin
			data_s2 <= conv;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = data_s2;
endmodule

// ===== rtl/hfc_checker.sv =====
// ----------------------------------------------------------------------------
// hfc_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module hfc_checker import hfc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);
	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed under stall");

	// accept when output free
	a_req_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request refused with empty output");

	// nothing out without an earlier accepted input
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("result without request");

	// stall input only behind a stalled result
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request stalled without output stall");
endmodule

bind half_float_converter hfc_checker u_hfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data (rsp.data)
);
